// ===== src/wsh_pkg.sv =====
// Shared types and constants for the WebAssembly section header parser.
`default_nettype none
package wsh_pkg;

  // Parameter defaults
  localparam int OFFSET_BITS_DEF   = 32;
  localparam int MAX_LEB_BYTES_DEF = 5;

  // Module header: magic "\0asm" then version 1, little-endian
  localparam logic [7:0] HDR_BYTES [8] = '{
    8'h00, 8'h61, 8'h73, 8'h6D, 8'h01, 8'h00, 8'h00, 8'h00
  };
  localparam int HDR_LAST_POS = 7;

  // ULEB128 decoding
  localparam logic [7:0] LEB_DATA_MASK  = 8'h7F;
  localparam int         LEB_CONT_BIT   = 7;
  localparam int         LEB_SHIFT_STEP = 7;
  // Bytes whose payload still lands inside 32 bits (shift below 35)
  localparam int         LEB_LIVE_BYTES = 5;

  // Result queue depth
  localparam int OUTQ_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_DESC       = 2'd0,
    KIND_NAME       = 2'd1,
    KIND_END        = 2'd2,
    KIND_NOT_MODULE = 2'd3
  } kind_t;

  typedef enum logic [6:0] {
    PH_HDR  = 7'b0000001,
    PH_TYPE = 7'b0000010,
    PH_SIZE = 7'b0000100,
    PH_NLEN = 7'b0001000,
    PH_NAME = 7'b0010000,
    PH_SKIP = 7'b0100000,
    PH_DONE = 7'b1000000
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  section_type;
    logic [31:0] body_offset;
    logic [31:0] body_size;
    logic [31:0] name_length;
    logic [7:0]  name_byte;
    logic [31:0] module_size;
    logic        final_res;
  } res_t;

  // Up to two results per input beat, in delivery order
  typedef struct packed {
    logic va;
    logic vb;
    res_t a;
    res_t b;
  } push_t;

endpackage
`default_nettype wire

// ===== src/wsh_leb.sv =====
// One-byte step of the ULEB128 size decoder.
`default_nettype none
module wsh_leb #(
  parameter int MAX_LEB_BYTES = wsh_pkg::MAX_LEB_BYTES_DEF,
  parameter int CW            = $clog2(MAX_LEB_BYTES + 1)
) (
  input  wire logic [7:0]    data_byte,
  input  wire logic [CW-1:0] cnt,
  input  wire logic [31:0]   val,
  output logic               done,
  output logic [CW-1:0]      cnt_nxt,
  output logic [31:0]        val_nxt
);

  logic [4:0]  sh;
  logic [31:0] dbits;
  logic [31:0] fed;
  logic        done_long;

  // Merge seven payload bits; bits above 31 fall off
  always_comb begin
    sh        = 5'(cnt) * 5'(wsh_pkg::LEB_SHIFT_STEP);
    dbits     = {24'b0, data_byte & wsh_pkg::LEB_DATA_MASK};
    fed       = (cnt < CW'(wsh_pkg::LEB_LIVE_BYTES)) ? (val | (dbits << sh)) : val;
    cnt_nxt   = cnt + CW'(1);
    done_long = data_byte[wsh_pkg::LEB_CONT_BIT] && (cnt_nxt >= CW'(MAX_LEB_BYTES));
    done      = !data_byte[wsh_pkg::LEB_CONT_BIT] || done_long;
    // Overlong number saturates to all ones
    val_nxt   = done_long ? '1 : fed;
  end

endmodule
`default_nettype wire

// ===== src/wsh_parser.sv =====
// Section walker state and per-byte result generation.
`default_nettype none
module wsh_parser #(
  parameter int OFFSET_BITS   = wsh_pkg::OFFSET_BITS_DEF,
  parameter int MAX_LEB_BYTES = wsh_pkg::MAX_LEB_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_file,
  output wsh_pkg::push_t  push
);

  localparam int OB = OFFSET_BITS;
  localparam int CW = $clog2(MAX_LEB_BYTES + 1);
  localparam int WB = (OB > 32) ? OB : 32;

  wsh_pkg::phase_t phase_r, phase_nxt, phase_step;
  logic [OB-1:0]   off_r, off_nxt;
  logic [31:0]     leb_val_r, leb_val_nxt;
  logic [CW-1:0]   leb_cnt_r, leb_cnt_nxt;
  logic [7:0]      type_r, type_nxt;
  logic [31:0]     skip_r, skip_nxt;
  logic [31:0]     held_r, held_nxt;
  logic            seen_r, seen_nxt;
  logic            good_r, good_nxt;

  logic            leb_done;
  logic [CW-1:0]   leb_cnt_fed;
  logic [31:0]     leb_val_fed;
  logic [OB-1:0]   next_off;
  logic [WB-1:0]   name_end_w;
  logic [31:0]     held_new;
  logic [31:0]     skip_dec;
  logic            step_v;
  logic            eof_v;
  wsh_pkg::res_t   step_res;
  wsh_pkg::res_t   eof_res;

  wsh_leb #(
    .MAX_LEB_BYTES(MAX_LEB_BYTES),
    .CW           (CW)
  ) u_leb (
    .data_byte(data_byte),
    .cnt      (leb_cnt_r),
    .val      (leb_val_r),
    .done     (leb_done),
    .cnt_nxt  (leb_cnt_fed),
    .val_nxt  (leb_val_fed)
  );

  // Advance the walker by one byte
  always_comb begin
    next_off    = off_r + OB'(1);
    name_end_w  = WB'(next_off) + WB'(leb_val_fed);
    held_new    = held_r - 32'(leb_cnt_fed) - leb_val_fed;
    skip_dec    = skip_r - 32'd1;

    phase_step  = phase_r;
    leb_val_nxt = leb_val_r;
    leb_cnt_nxt = leb_cnt_r;
    type_nxt    = type_r;
    skip_nxt    = skip_r;
    held_nxt    = held_r;
    seen_nxt    = seen_r;
    good_nxt    = good_r;
    step_v      = 1'b0;
    step_res    = '0;

    case (phase_r)
      wsh_pkg::PH_HDR: begin
        good_nxt = good_r && (data_byte == wsh_pkg::HDR_BYTES[off_r[2:0]]);
        if (off_r >= OB'(wsh_pkg::HDR_LAST_POS)) begin
          if (good_nxt) begin
            phase_step = wsh_pkg::PH_TYPE;
          end else begin
            step_v        = 1'b1;
            step_res.kind = wsh_pkg::KIND_NOT_MODULE;
            phase_step    = wsh_pkg::PH_DONE;
          end
        end
      end
      wsh_pkg::PH_TYPE: begin
        type_nxt    = data_byte;
        leb_val_nxt = '0;
        leb_cnt_nxt = '0;
        phase_step  = wsh_pkg::PH_SIZE;
      end
      wsh_pkg::PH_SIZE: begin
        leb_val_nxt = leb_val_fed;
        leb_cnt_nxt = leb_cnt_fed;
        if (leb_done) begin
          if (type_r == 8'd0 && leb_val_fed == 32'd0) begin
            // Empty custom section marks the end of the module
            step_v               = 1'b1;
            step_res.kind        = wsh_pkg::KIND_END;
            step_res.module_size = 32'(next_off);
            phase_step           = wsh_pkg::PH_DONE;
          end else if (type_r == 8'd0) begin
            held_nxt    = leb_val_fed;
            leb_val_nxt = '0;
            leb_cnt_nxt = '0;
            phase_step  = wsh_pkg::PH_NLEN;
          end else begin
            step_v                = 1'b1;
            step_res.kind         = wsh_pkg::KIND_DESC;
            step_res.section_type = type_r;
            step_res.body_offset  = 32'(next_off);
            step_res.body_size    = leb_val_fed;
            seen_nxt              = 1'b1;
            skip_nxt              = leb_val_fed;
            phase_step = (leb_val_fed != 32'd0) ? wsh_pkg::PH_SKIP : wsh_pkg::PH_TYPE;
          end
        end
      end
      wsh_pkg::PH_NLEN: begin
        leb_val_nxt = leb_val_fed;
        leb_cnt_nxt = leb_cnt_fed;
        if (leb_done) begin
          held_nxt             = held_new;
          step_v               = 1'b1;
          step_res.kind        = wsh_pkg::KIND_DESC;
          step_res.body_offset = 32'(OB'(name_end_w));
          step_res.body_size   = held_new;
          step_res.name_length = leb_val_fed;
          seen_nxt             = 1'b1;
          if (leb_val_fed != 32'd0) begin
            skip_nxt   = leb_val_fed;
            phase_step = wsh_pkg::PH_NAME;
          end else begin
            skip_nxt   = held_new;
            phase_step = (held_new != 32'd0) ? wsh_pkg::PH_SKIP : wsh_pkg::PH_TYPE;
          end
        end
      end
      wsh_pkg::PH_NAME: begin
        step_v             = 1'b1;
        step_res.kind      = wsh_pkg::KIND_NAME;
        step_res.name_byte = data_byte;
        skip_nxt           = skip_dec;
        if (skip_dec == 32'd0) begin
          skip_nxt   = held_r;
          phase_step = (held_r != 32'd0) ? wsh_pkg::PH_SKIP : wsh_pkg::PH_TYPE;
        end
      end
      wsh_pkg::PH_SKIP: begin
        skip_nxt = skip_dec;
        if (skip_dec == 32'd0) begin
          phase_step = wsh_pkg::PH_TYPE;
        end
      end
      default: begin
      end
    endcase

    // Close the file on its last byte
    eof_v   = 1'b0;
    eof_res = '0;
    if (end_of_file) begin
      if (phase_step == wsh_pkg::PH_HDR) begin
        eof_v        = 1'b1;
        eof_res.kind = wsh_pkg::KIND_NOT_MODULE;
      end else if (phase_step != wsh_pkg::PH_DONE) begin
        eof_v               = 1'b1;
        eof_res.kind        = wsh_pkg::KIND_END;
        eof_res.module_size = seen_nxt ? 32'(next_off) : 32'd0;
      end
    end

    phase_nxt = phase_step;
    off_nxt   = next_off;
    if (end_of_file) begin
      phase_nxt   = wsh_pkg::PH_HDR;
      off_nxt     = '0;
      leb_val_nxt = '0;
      leb_cnt_nxt = '0;
      type_nxt    = '0;
      skip_nxt    = '0;
      held_nxt    = '0;
      seen_nxt    = 1'b0;
      good_nxt    = 1'b1;
    end

    // Order results and flag the last one of the beat
    push.va = accept && (step_v || eof_v);
    push.vb = accept && step_v && eof_v;
    push.a  = step_v ? step_res : eof_res;
    push.a.final_res = !(step_v && eof_v);
    push.b  = eof_res;
    push.b.final_res = 1'b1;
  end

  // Hold state between accepted beats
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= wsh_pkg::PH_HDR;
      off_r     <= '0;
      leb_val_r <= '0;
      leb_cnt_r <= '0;
      type_r    <= '0;
      skip_r    <= '0;
      held_r    <= '0;
      seen_r    <= 1'b0;
      good_r    <= 1'b1;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      off_r     <= off_nxt;
      leb_val_r <= leb_val_nxt;
      leb_cnt_r <= leb_cnt_nxt;
      type_r    <= type_nxt;
      skip_r    <= skip_nxt;
      held_r    <= held_nxt;
      seen_r    <= seen_nxt;
      good_r    <= good_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/wsh_outq.sv =====
// Small result queue taking up to two results per cycle, giving one.
`default_nettype none
module wsh_outq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire wsh_pkg::push_t push,
  input  wire logic           pop,
  output logic                full,
  output logic                head_valid,
  output wsh_pkg::res_t       head
);

  localparam int DEPTH = wsh_pkg::OUTQ_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int NW    = $clog2(DEPTH + 1);

  wsh_pkg::res_t mem_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt;
  logic [PW-1:0] rd_r, rd_nxt;
  logic [NW-1:0] cnt_r, cnt_nxt;

  // Advance pointers and fill count
  always_comb begin
    wr_nxt  = wr_r + PW'(push.va) + PW'(push.vb);
    rd_nxt  = rd_r + PW'(pop);
    cnt_nxt = cnt_r + NW'(push.va) + NW'(push.vb) - NW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store pushed results
  always_ff @(posedge clk) begin
    if (push.va) begin
      mem_r[wr_r] <= push.a;
    end
    if (push.vb) begin
      mem_r[wr_r + PW'(1)] <= push.b;
    end
  end

  // Keep room for two results of the next beat
  assign full       = (cnt_r >= NW'(DEPTH - 1));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_r];

endmodule
`default_nettype wire

// ===== src/wasm_section_header_parser_core.sv =====
// Top level of the WebAssembly module header and section walker.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid, in_stall, in_data_byte, ...   | bytes in
//   out     | out_valid, out_stall, out_kind, ...     | results out
//
// One byte is taken per clock while in_stall is low; its state update is
// finished in that cycle. Results go into a four-entry queue that drives the
// out_ ports; a byte that gives two results (a descriptor or name byte followed
// by end of module) hands them out in turn. in_stall rises while three or more
// results wait. rst_n is synchronous: it clears the walker and empties the queue.
`default_nettype none
module wasm_section_header_parser_core #(
  parameter int OFFSET_BITS   = wsh_pkg::OFFSET_BITS_DEF,
  parameter int MAX_LEB_BYTES = wsh_pkg::MAX_LEB_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_end_of_file,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_section_type,
  output logic [31:0]      out_body_offset,
  output logic [31:0]      out_body_size,
  output logic [31:0]      out_name_length,
  output logic [7:0]       out_name_byte,
  output logic [31:0]      out_module_size,
  output logic             out_final_res
);

  logic           accept;
  logic           q_full;
  logic           pop;
  wsh_pkg::push_t push;
  wsh_pkg::res_t  head;

  // Take a beat while the queue has room for two results
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign pop      = out_valid && !out_stall;

  wsh_parser #(
    .OFFSET_BITS  (OFFSET_BITS),
    .MAX_LEB_BYTES(MAX_LEB_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .data_byte  (in_data_byte),
    .end_of_file(in_end_of_file),
    .push       (push)
  );

  wsh_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (pop),
    .full      (q_full),
    .head_valid(out_valid),
    .head      (head)
  );

  // Unpack the head result onto the ports
  assign out_kind         = head.kind;
  assign out_section_type = head.section_type;
  assign out_body_offset  = head.body_offset;
  assign out_body_size    = head.body_size;
  assign out_name_length  = head.name_length;
  assign out_name_byte    = head.name_byte;
  assign out_module_size  = head.module_size;
  assign out_final_res    = head.final_res;

endmodule
`default_nettype wire
